@@ hdl/occ_pkg.sv @@
package occ_pkg;

  localparam int unsigned COUNT_W       = 16;
  localparam int unsigned CFG_W         = 11;
  localparam int unsigned ROW_WIDTH_RST = 256;

  localparam logic signed [COUNT_W-1:0] GROUND_COUNT = -16'sd1;
  localparam logic signed [COUNT_W-1:0] FREE_COUNT   = 16'sd1;
  localparam logic signed [COUNT_W-1:0] OCC_LO_MIN   = 16'sd2;
  localparam logic signed [COUNT_W-1:0] OCC_LO_MAX   = 16'sd4;
  localparam logic signed [COUNT_W-1:0] SPECIAL_MIN  = 16'sd5;
  localparam logic signed [COUNT_W-1:0] SPECIAL_MAX  = 16'sd19;
  localparam logic signed [COUNT_W-1:0] OCC_HI_MIN   = 16'sd20;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX    = 16'sd32767;
  localparam logic signed [COUNT_W-1:0] UNSEEN_COUNT = 16'sd0;

  typedef enum logic [1:0] {
    CLS_FREE    = 2'd0,
    CLS_OCC     = 2'd1,
    CLS_UNKNOWN = 2'd2,
    CLS_SPECIAL = 2'd3
  } occ_class_e;

  // One window entry: in-grid flag and raw count.
  typedef struct packed {
    logic                      in_grid;
    logic signed [COUNT_W-1:0] count;
  } occ_entry_t;

  localparam int unsigned ENTRY_W = $bits(occ_entry_t);

  // Cell under test and its four neighbors; in_grid already folded with validity.
  typedef struct packed {
    occ_entry_t center;
    occ_entry_t left;
    occ_entry_t right;
    occ_entry_t above;
    occ_entry_t below;
  } occ_nbhd_t;

endpackage

@@ hdl/occupancy_cell_classifier_unit.sv @@
// Channel   Direction  Payload (low bit first)             Handshake
// s_axis    in         tdata: cell_count[15:0]             tvalid / tready
//                      tuser: is_pad[0]
// m_axis    out        tdata: cell_class[1:0], zero fill   tvalid / tready
// cfg       in         cfg_wdata_i: row_width[10:0]        cfg_we_i, no wait
//
// One item per clock sustained while the sink keeps up; a result leaves once
// the item that completes its neighborhood has passed the registered read of
// the window RAMs and then the result register.
// Results lag the input by one row; pad items and cells before the window
// fills produce no result.
// Reset: row_width 256 (clamped to MAX_WIDTH), window empty via a fill count,
// so no clearing pass is needed.
// A stalled result holds in the output register while the next item still
// enters the read stage; input stalls only when both stages are full and the
// sink holds off.
module occupancy_cell_classifier_unit
  import occ_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // cfg: row_width
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] cell_count
  input  logic [0:0]        s_axis_tuser,   // [0] is_pad
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata    // [1:0] cell_class, [7:2] zero
);

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned W_RST = (ROW_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : ROW_WIDTH_RST;

  logic [WW-1:0] width_q, width_d;
  logic          acc;
  logic          room;
  logic          s1_adv;
  logic          s1_valid_q, s1_valid_d;
  logic          out_valid_q, out_valid_d;
  occ_class_e    out_cls_q;
  occ_nbhd_t     nbhd;
  logic          has_result;
  occ_class_e    cls;

  // Clamp the written width: zero acts as one, oversize acts as MAX_WIDTH.
  function automatic logic [WW-1:0] clamp_width(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return WW'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      return WW'(MAX_WIDTH);
    end
    return WW'(v);
  endfunction

  assign width_d = cfg_we_i ? clamp_width(cfg_wdata_i) : width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WW'(W_RST);
    end else begin
      width_q <= width_d;
    end
  end

  // Handshake: the read stage moves on when the result register is free or draining.
  assign room          = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && room;
  assign s_axis_tready = !s1_valid_q || room;
  assign acc           = s_axis_tvalid && s_axis_tready;

  occ_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .cell_count_i (s_axis_tdata),
    .is_pad_i     (s_axis_tuser[0]),
    .width_i      (width_q),
    .nbhd_o       (nbhd)
  );

  occ_classify u_classify (
    .nbhd_i       (nbhd),
    .has_result_o (has_result),
    .cls_o        (cls)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    // Drop items whose center cell is not a grid cell.
    if (room) begin
      out_valid_d = s1_adv && has_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_cls_q <= cls;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_cls_q};

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  a_acc_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> s1_valid_q) else $error("accepted item missing from read stage");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv))
    else $error("result appeared without a read stage advance");

endmodule

@@ hdl/occ_ram.sv @@
module occ_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 2049
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

@@ hdl/occ_window.sv @@
module occ_window
  import occ_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  logic signed [COUNT_W-1:0]        cell_count_i,
  input  logic                             is_pad_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   width_i,
  output occ_nbhd_t                        nbhd_o
);

  localparam int unsigned DEPTH = 2 * MAX_WIDTH + 1;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned FW    = $clog2(DEPTH + 1);

  logic [PW-1:0] pos_q, pos_d;
  logic [FW-1:0] fill_q, fill_d;

  logic [PW-1:0] k_center, k_left, k_right, k_above;
  logic [PW-1:0] a_center, a_left, a_right, a_above;
  occ_entry_t    new_entry;

  logic          v_center_q, v_left_q, v_right_q, v_above_q;
  logic          right_new_q;
  occ_entry_t    below_q;
  occ_entry_t    rd_center, rd_left, rd_right, rd_above;

  // Slot k items back from the newest write position.
  function automatic logic [PW-1:0] back_addr(input logic [PW-1:0] p, input logic [PW-1:0] k);
    logic [PW:0] diff;
    diff = {1'b0, p} - {1'b0, k};
    if (diff[PW]) begin
      diff = diff + (PW+1)'(DEPTH);
    end
    return diff[PW-1:0];
  endfunction

  assign pos_d  = (pos_q == PW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
  assign fill_d = (fill_q == FW'(DEPTH)) ? fill_q : fill_q + 1'b1;

  assign k_center = PW'(width_i);
  assign k_left   = PW'(width_i) + 1'b1;
  assign k_right  = PW'(width_i) - 1'b1;
  assign k_above  = PW'(width_i) << 1;

  assign a_center = back_addr(pos_d, k_center);
  assign a_left   = back_addr(pos_d, k_left);
  assign a_right  = back_addr(pos_d, k_right);
  assign a_above  = back_addr(pos_d, k_above);

  assign new_entry.in_grid = ~is_pad_i;
  assign new_entry.count   = is_pad_i ? '0 : cell_count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else if (acc_i) begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

  // Entry k back is written since reset when k is below the new fill count.
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      v_center_q  <= FW'(k_center) < fill_d;
      v_left_q    <= FW'(k_left) < fill_d;
      v_right_q   <= FW'(k_right) < fill_d;
      v_above_q   <= FW'(k_above) < fill_d;
      right_new_q <= (k_right == '0);
      below_q     <= new_entry;
    end
  end

  occ_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_vert (
    .clk_i     (clk_i),
    .we_i      (acc_i),
    .waddr_i   (pos_d),
    .wdata_i   (new_entry),
    .re_i      (acc_i),
    .raddr_a_i (a_center),
    .raddr_b_i (a_above),
    .rdata_a_o (rd_center),
    .rdata_b_o (rd_above)
  );

  occ_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_horz (
    .clk_i     (clk_i),
    .we_i      (acc_i),
    .waddr_i   (pos_d),
    .wdata_i   (new_entry),
    .re_i      (acc_i),
    .raddr_a_i (a_left),
    .raddr_b_i (a_right),
    .rdata_a_o (rd_left),
    .rdata_b_o (rd_right)
  );

  always_comb begin
    nbhd_o.center.count    = rd_center.count;
    nbhd_o.center.in_grid  = rd_center.in_grid & v_center_q;
    nbhd_o.left.count      = rd_left.count;
    nbhd_o.left.in_grid    = rd_left.in_grid & v_left_q;
    nbhd_o.above.count     = rd_above.count;
    nbhd_o.above.in_grid   = rd_above.in_grid & v_above_q;
    nbhd_o.below           = below_q;
    // Right neighbor is the item just written when a row holds one cell.
    if (right_new_q) begin
      nbhd_o.right = below_q;
    end else begin
      nbhd_o.right.count   = rd_right.count;
      nbhd_o.right.in_grid = rd_right.in_grid & v_right_q;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(DEPTH)) else $error("window fill count past depth");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && fill_q != FW'(DEPTH) |=> fill_q == $past(fill_q) + 1'b1)
    else $error("fill count did not advance with item");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(DEPTH - 1)) else $error("write position past depth");

endmodule

@@ hdl/occ_classify.sv @@
module occ_classify
  import occ_pkg::*;
(
  input  occ_nbhd_t  nbhd_i,
  output logic       has_result_o,
  output occ_class_e cls_o
);

  logic signed [COUNT_W-1:0] v;
  logic                      lin_unseen;
  logic                      any_ground;

  assign v            = nbhd_i.center.count;
  assign has_result_o = nbhd_i.center.in_grid;

  assign lin_unseen = nbhd_i.left.in_grid  && nbhd_i.left.count  == UNSEEN_COUNT &&
                      nbhd_i.right.in_grid && nbhd_i.right.count == UNSEEN_COUNT;
  assign any_ground = (nbhd_i.left.in_grid  && nbhd_i.left.count  == GROUND_COUNT) ||
                      (nbhd_i.right.in_grid && nbhd_i.right.count == GROUND_COUNT) ||
                      (nbhd_i.above.in_grid && nbhd_i.above.count == GROUND_COUNT) ||
                      (nbhd_i.below.in_grid && nbhd_i.below.count == GROUND_COUNT);

  always_comb begin
    if (v == FREE_COUNT) begin
      cls_o = CLS_FREE;
    end else if (v inside {[OCC_LO_MIN:OCC_LO_MAX], [OCC_HI_MIN:COUNT_MAX]}) begin
      cls_o = CLS_OCC;
    end else if (v inside {[SPECIAL_MIN:SPECIAL_MAX]}) begin
      cls_o = CLS_SPECIAL;
    end else if (v == UNSEEN_COUNT) begin
      cls_o = lin_unseen ? CLS_UNKNOWN : CLS_FREE;
    end else if (v == GROUND_COUNT) begin
      cls_o = any_ground ? CLS_OCC : CLS_FREE;
    end else begin
      cls_o = CLS_FREE;
    end
  end

endmodule

@@ tb/tb_occupancy_cell_classifier_unit.sv @@
module tb_occupancy_cell_classifier_unit;
  import occ_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned WIN_DEPTH = 2 * MAX_WIDTH + 1;
  // Cycles to let the result pipeline settle before a register write or the end.
  localparam int unsigned DRAIN     = 8;
  localparam int unsigned LIMIT     = 200000;

  // One input item plus an optional typed expectation (directed rows only).
  typedef struct packed {
    bit                        pad;
    logic signed [COUNT_W-1:0] cnt;
    bit                        typed;
    bit                        has;
    occ_class_e                cls;
  } cell_item_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;   // [15:0] cell_count
  logic [0:0]        s_axis_tuser  = '0;   // [0] is_pad
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;         // [1:0] cell_class, [7:2] zero

  occupancy_cell_classifier_unit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the classifier: window of past items, write pointer, row width.
  occ_entry_t       win_q [WIN_DEPTH];
  int unsigned      win_pos;
  logic [CFG_W-1:0] width_reg;

  cell_item_t  cell_fifo [$];
  occ_class_e  class_q [$];
  cell_item_t  cur_item;
  int          cells_pending = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          err_count     = 0;
  int          n_items       = 0;
  int          n_results     = 0;
  int unsigned cycles        = 0;

  function automatic int unsigned eff_row_width();
    int unsigned w;
    w = 32'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  // Entry written k items ago; k = 0 is the newest.
  function automatic occ_entry_t win_back(int unsigned k);
    return win_q[(win_pos + WIN_DEPTH - (k % WIN_DEPTH)) % WIN_DEPTH];
  endfunction

  function automatic bit holds_code(occ_entry_t e, logic signed [COUNT_W-1:0] code);
    return e.in_grid && (e.count == code);
  endfunction

  // Shift one item into the window and classify the cell one row back.
  task automatic predict_cell(input bit pad, input logic signed [COUNT_W-1:0] cnt,
                              output bit has, output occ_class_e cls);
    int unsigned w;
    occ_entry_t c;
    logic signed [COUNT_W-1:0] v;
    w = eff_row_width();
    win_pos = (win_pos + 1) % WIN_DEPTH;
    win_q[win_pos].in_grid = !pad;
    win_q[win_pos].count   = pad ? '0 : cnt;
    c = win_back(w);
    has = c.in_grid;
    v = c.count;
    cls = CLS_FREE;
    if (v == FREE_COUNT) begin
      cls = CLS_FREE;
    end else if ((v >= OCC_LO_MIN && v <= OCC_LO_MAX) || v >= OCC_HI_MIN) begin
      cls = CLS_OCC;
    end else if (v >= SPECIAL_MIN) begin
      cls = CLS_SPECIAL;
    end else if (v == UNSEEN_COUNT) begin
      // unknown only when both stream neighbors are unseen grid cells
      if (holds_code(win_back(w + 1), UNSEEN_COUNT) &&
          holds_code(win_back(w - 1), UNSEEN_COUNT)) cls = CLS_UNKNOWN;
    end else if (v == GROUND_COUNT) begin
      // occupied when any of left, right, above, below is ground
      if (holds_code(win_back(w + 1), GROUND_COUNT) ||
          holds_code(win_back(w - 1), GROUND_COUNT) ||
          holds_code(win_back(2 * w), GROUND_COUNT) ||
          holds_code(win_back(0), GROUND_COUNT)) cls = CLS_OCC;
    end
  endtask

  task automatic report_error(input string what, input int got, input int want);
    $display("[%0t] class error: %s got %0d want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic queue_cell(input cell_item_t it);
    cell_fifo = {cell_fifo, it};
    cells_pending++;
  endtask

  // Skew toward the class boundaries, ground and unseen cells; keep some raw noise.
  function automatic logic signed [COUNT_W-1:0] pick_count();
    int r;
    int x;
    r = $urandom_range(0, 99);
    if (r < 25) return GROUND_COUNT;
    if (r < 47) return UNSEEN_COUNT;
    if (r < 55) return FREE_COUNT;
    if (r < 63) return COUNT_W'($urandom_range(2, 4));
    if (r < 73) return COUNT_W'($urandom_range(5, 19));
    if (r < 80) return COUNT_W'($urandom_range(20, 40));
    if (r < 88) return COUNT_W'($urandom_range(41, 32767));
    if (r < 92) return COUNT_MAX;
    if (r < 97) begin
      x = $urandom_range(2, 32768);
      return COUNT_W'(-x);
    end
    return COUNT_W'($urandom());
  endfunction

  // Queue grids of random length, each followed by a flush run (or none, so
  // grids run back to back); stray pads sprinkle in as noise.
  task automatic queue_random(input int budget);
    int unsigned w;
    int left;
    int n;
    int npad;
    cell_item_t it;
    w = eff_row_width();
    left = budget;
    while (left > 0) begin
      n = (w >= 64) ? left : $urandom_range(1, 6 * w + 2);
      if (n > left) n = left;
      for (int k = 0; k < n; k++) begin
        it = '0;
        it.pad = ($urandom_range(0, 99) < 3);
        it.cnt = it.pad ? COUNT_W'($urandom()) : pick_count();
        queue_cell(it);
      end
      left -= n;
      if (w < 64) begin
        npad = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 2 * w + 1);
        for (int k = 0; k < npad; k++) begin
          it = '0;
          it.pad = 1'b1;
          it.cnt = COUNT_W'($urandom());
          queue_cell(it);
        end
      end
    end
  endtask

  // Hold until every item is in and every result is out, then let the pipe drain.
  task automatic wait_idle();
    do @(posedge clk_i); while (cells_pending != 0 || class_q.size() != 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_row_width(input logic [CFG_W-1:0] w);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    width_reg   = w;
  endtask

  // Source side: predict on acceptance, then present the next item or idle.
  always @(posedge clk_i) begin : drive_cells
    bit has;
    occ_class_e cls;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_cell(cur_item.pad, cur_item.cnt, has, cls);
        if (cur_item.typed) begin
          has = cur_item.has;
          cls = cur_item.cls;
        end
        if (has) class_q = {class_q, cls};
        cells_pending--;
        n_items++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cell_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = cell_fifo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_item.cnt;
          s_axis_tuser  <= cur_item.pad;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: random back-pressure, compare each result with the oldest class.
  always @(posedge clk_i) begin : check_classes
    occ_class_e want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (class_q.size() == 0) begin
          report_error("unexpected result, class", int'(m_axis_tdata[1:0]), -1);
        end else begin
          want = class_q.pop_front();
          if (m_axis_tdata[1:0] != want) begin
            report_error("cell_class", int'(m_axis_tdata[1:0]), int'(want));
          end
          if (m_axis_tdata[7:2] != '0) begin
            report_error("tdata fill", int'(m_axis_tdata[7:2]), 0);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, class_q.size());
      $display("occupancy_cell_classifier_unit: mismatch");
      $finish;
    end
  end

  initial begin
    cell_item_t dir_tab [25];
    for (int i = 0; i < WIN_DEPTH; i++) win_q[i] = '0;
    win_pos   = 0;
    width_reg = CFG_W'(ROW_WIDTH_RST);

    // Directed rows at row width 2: a row's typed class belongs to the cell
    // two items earlier, whose neighborhood that row completes.
    dir_tab = '{
      // flush the previous grid; the first two pads still classify its tail
      '{1'b1, 16'sh5A5A, 1'b0, 1'b0, CLS_FREE},
      '{1'b1, 16'shA5A5, 1'b0, 1'b0, CLS_FREE},
      '{1'b1, 16'sh0000, 1'b1, 1'b0, CLS_FREE},
      '{1'b1, 16'shFFFF, 1'b1, 1'b0, CLS_FREE},
      '{1'b1, 16'sh0001, 1'b1, 1'b0, CLS_FREE},
      // window start: classified slot still holds a pad
      '{1'b0, 16'sd1,     1'b1, 1'b0, CLS_FREE},
      '{1'b0, 16'sd32767, 1'b1, 1'b0, CLS_FREE},
      // class boundaries: 1 free, 32767 and 2 occupied, 4 occupied, 5 and 19 special, 20 occupied
      '{1'b0, 16'sd2,  1'b1, 1'b1, CLS_FREE},
      '{1'b0, 16'sd4,  1'b1, 1'b1, CLS_OCC},
      '{1'b0, 16'sd5,  1'b1, 1'b1, CLS_OCC},
      '{1'b0, 16'sd19, 1'b1, 1'b1, CLS_OCC},
      '{1'b0, 16'sd20, 1'b1, 1'b1, CLS_SPECIAL},
      '{1'b0, 16'sd0,  1'b1, 1'b1, CLS_SPECIAL},
      '{1'b0, 16'sd0,  1'b1, 1'b1, CLS_OCC},
      // unseen with a seen left neighbor, then unseen between two unseen
      '{1'b0, 16'sd0,  1'b1, 1'b1, CLS_FREE},
      '{1'b0, -16'sd1, 1'b1, 1'b1, CLS_UNKNOWN},
      // unseen beside ground, ground beside ground on each side
      '{1'b0, -16'sd1,     1'b1, 1'b1, CLS_FREE},
      '{1'b0, -16'sd2,     1'b1, 1'b1, CLS_OCC},
      '{1'b0, -16'sd32768, 1'b1, 1'b1, CLS_OCC},
      // other negatives are free and never count as ground
      '{1'b0, -16'sd1, 1'b1, 1'b1, CLS_FREE},
      '{1'b1, 16'sh7FFF, 1'b1, 1'b1, CLS_FREE},
      // ground whose neighbors are other negatives or outside the grid
      '{1'b1, 16'sh8000, 1'b1, 1'b1, CLS_FREE},
      '{1'b1, 16'sh1234, 1'b1, 1'b0, CLS_FREE},
      '{1'b0, 16'sd0,    1'b1, 1'b0, CLS_FREE},
      '{1'b0, -16'sd1,   1'b1, 1'b0, CLS_FREE}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender idles 30 %, receiver 57 %.
    send_idle_pct = 30;
    recv_idle_pct = 57;
    // Reset row width first, before any register write.
    queue_random(300);
    wait_idle();
    write_row_width(CFG_W'(2));
    foreach (dir_tab[i]) queue_cell(dir_tab[i]);
    wait_idle();
    write_row_width(CFG_W'(1));
    queue_random(20);
    wait_idle();

    // Swap the idle rates.
    send_idle_pct = 57;
    recv_idle_pct = 30;
    write_row_width(CFG_W'(0));
    queue_random(15);
    wait_idle();
    write_row_width(CFG_W'(3));
    queue_random(20);
    wait_idle();
    write_row_width(CFG_W'(MAX_WIDTH));
    queue_random(10);
    wait_idle();

    // No idling; the widest setting reuses the window left by the last phase.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_row_width({CFG_W{1'b1}});
    queue_random(10);
    wait_idle();
    write_row_width(CFG_W'(5));
    queue_random(15);
    wait_idle();
    write_row_width(CFG_W'(7));
    queue_random(15);
    wait_idle();
    write_row_width(CFG_W'(17));
    queue_random(20);
    wait_idle();
    repeat (DRAIN) @(posedge clk_i);

    $display("%0d items in, %0d classes compared, %0d errors", n_items, n_results, err_count);
    $display("row widths: reset 256, 0, 1, 2, 3, 5, 7, 17, 1024 and 2047 (clamped)");
    if (err_count == 0) begin
      $display("occupancy_cell_classifier_unit: match");
    end else begin
      $display("occupancy_cell_classifier_unit: mismatch");
    end
    $finish;
  end

endmodule
